// File: hw/rtl/seed_text_parser_macros.svh
// ----------------------------------------------------------------------------
// Seed text parser assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef SEED_TEXT_PARSER_MACROS_SVH
`define SEED_TEXT_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define STP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stp assertion failed");

// next-cycle implication
`define STP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stp assertion failed");

`else

`define STP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define STP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Types, character codes and helper functions for the seed text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    localparam logic [4:0] COUNT_SATURATE      = 5'd17;
    localparam logic [4:0] MAX_BARE_HEX_DIGITS = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [1:0] PATH_PREFIX_HEX = 2'd0;
    localparam logic [1:0] PATH_DECIMAL    = 2'd1;
    localparam logic [1:0] PATH_BARE_HEX   = 2'd2;
    localparam logic [1:0] PATH_HASH       = 2'd3;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] text_byte;
        logic       is_last;
    } stp_in_t;

    typedef struct packed {
        logic [63:0] seed_value;
        logic [1:0]  status;
        logic [1:0]  path_taken;
    } stp_out_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            r = {1'b0, 4'(b - CH_ZERO)};
        end
        else if (b >= CH_UA && b <= CH_UF)
        begin
            r = {1'b0, 4'(b - CH_UA + 8'd10)};
        end
        else if (b >= CH_LA && b <= CH_LF)
        begin
            r = {1'b0, 4'(b - CH_LA + 8'd10)};
        end
        return r;
    endfunction

    // one FNV-1a round; prime is 2^40 + 0x1b3, done as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stp_in_if.sv
// ----------------------------------------------------------------------------
// stp_in_if
// Text byte channel: valid/ready handshake with one byte request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_in_if;
    logic             valid;
    logic             ready;
    stp_pkg::stp_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/stp_out_if.sv
// ----------------------------------------------------------------------------
// stp_out_if
// Seed result channel: valid/ready handshake carrying one parsed seed.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_out_if;
    logic              valid;
    logic              ready;
    stp_pkg::stp_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/seed_text_parser.sv
// ----------------------------------------------------------------------------
// seed_text_parser
// Streams seed text bytes and returns a 64-bit seed at the end of the string.
// ----------------------------------------------------------------------------
// Takes one text request per clock, back to back. Each request is captured in
// an input register and from there updates the running FNV-1a hash and the
// decimal, bare hex and prefixed hex accumulators in one pass; on the request
// marked last the seed is chosen and loaded into the result register, from
// which it is presented. The result register decouples the sides: only a last
// request waiting behind an untaken seed stalls the input. The cycle time is
// set by the hash update, a constant multiply done as a shift-add tree.
`default_nettype none

`include "seed_text_parser_macros.svh"

module seed_text_parser
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stp_in_if.sink     text,
    stp_out_if.source  seed
);

    // input register
    logic             in_valid_reg;
    stp_pkg::stp_in_t in_data_reg;

    // parser state
    logic [63:0] hash_reg,       hash_next;
    logic [4:0]  count_reg,      count_next;
    logic        first_zero_reg, first_zero_next;
    logic        second_x_reg,   second_x_next;
    logic        only_dec_reg,   only_dec_next;
    logic        only_hex_reg,   only_hex_next;
    logic [63:0] dec_reg,        dec_next;
    logic        dec_ovf_reg,    dec_ovf_next;
    logic [63:0] bare_reg,       bare_next;
    logic [63:0] pfx_reg,        pfx_next;
    logic        pfx_open_reg,   pfx_open_next;
    logic        pfx_ovf_reg,    pfx_ovf_next;

    // result register
    logic              out_valid_reg;
    stp_pkg::stp_out_t out_data_reg;
    stp_pkg::stp_out_t result;

    logic        advance;
    logic        take_last;
    logic [7:0]  b;
    logic        is_drop;
    logic        is_dec;
    logic [4:0]  nib;
    logic [67:0] dec_wide;

    assign advance   = in_valid_reg &&
                       (!in_data_reg.is_last || !out_valid_reg || seed.ready);
    assign take_last = advance && in_data_reg.is_last;

    assign text.ready = !in_valid_reg || advance;
    assign seed.valid = out_valid_reg;
    assign seed.data  = out_data_reg;

    assign b        = in_data_reg.text_byte;
    assign is_drop  = (b == stp_pkg::CH_SPACE) || (b == stp_pkg::CH_DASH);
    assign is_dec   = (b >= stp_pkg::CH_ZERO) && (b <= stp_pkg::CH_NINE);
    assign nib      = stp_pkg::hex_nibble(b);
    assign dec_wide = ({4'd0, dec_reg} << 3) + ({4'd0, dec_reg} << 1)
                    + {64'd0, nib[3:0]};

    always_comb
    begin
        hash_next       = hash_reg;
        count_next      = count_reg;
        first_zero_next = first_zero_reg;
        second_x_next   = second_x_reg;
        only_dec_next   = only_dec_reg;
        only_hex_next   = only_hex_reg;
        dec_next        = dec_reg;
        dec_ovf_next    = dec_ovf_reg;
        bare_next       = bare_reg;
        pfx_next        = pfx_reg;
        pfx_open_next   = pfx_open_reg;
        pfx_ovf_next    = pfx_ovf_reg;

        if (in_data_reg.has_byte)
        begin
            hash_next = stp_pkg::fnv_step(hash_reg, b);
            if (!is_drop)
            begin
                if (count_reg == 5'd0)
                begin
                    first_zero_next = (b == stp_pkg::CH_ZERO);
                end
                if (count_reg == 5'd1)
                begin
                    second_x_next = (b == stp_pkg::CH_LX) || (b == stp_pkg::CH_UX);
                end

                if (is_dec)
                begin
                    dec_next = dec_wide[63:0];
                    if (dec_wide[67:64] != 4'd0)
                    begin
                        dec_ovf_next = 1'b1;
                    end
                end
                else
                begin
                    only_dec_next = 1'b0;
                end

                if (!nib[4])
                begin
                    bare_next = {bare_reg[59:0], nib[3:0]};
                end
                else
                begin
                    only_hex_next = 1'b0;
                end

                if (count_reg >= 5'd2 && pfx_open_reg)
                begin
                    if (!nib[4])
                    begin
                        if (pfx_reg[63:60] != 4'd0)
                        begin
                            pfx_ovf_next = 1'b1;
                        end
                        pfx_next = {pfx_reg[59:0], nib[3:0]};
                    end
                    else
                    begin
                        pfx_open_next = 1'b0;
                    end
                end

                if (count_reg < stp_pkg::COUNT_SATURATE)
                begin
                    count_next = count_reg + 5'd1;
                end
            end
        end
    end

    // path selection on the updated state
    always_comb
    begin
        result.seed_value = 64'd0;
        result.status     = stp_pkg::STATUS_OK;
        result.path_taken = stp_pkg::PATH_PREFIX_HEX;
        if (count_next == 5'd0)
        begin
            result.status = stp_pkg::STATUS_EMPTY;
        end
        else if (count_next > 5'd2 && first_zero_next && second_x_next)
        begin
            if (pfx_ovf_next)
            begin
                result.status = stp_pkg::STATUS_RANGE;
            end
            else
            begin
                result.seed_value = pfx_next;
            end
        end
        else if (only_dec_next)
        begin
            result.path_taken = stp_pkg::PATH_DECIMAL;
            if (dec_ovf_next)
            begin
                result.status = stp_pkg::STATUS_RANGE;
            end
            else
            begin
                result.seed_value = dec_next;
            end
        end
        else if (only_hex_next && count_next <= stp_pkg::MAX_BARE_HEX_DIGITS)
        begin
            result.path_taken = stp_pkg::PATH_BARE_HEX;
            result.seed_value = bare_next;
        end
        else
        begin
            result.path_taken = stp_pkg::PATH_HASH;
            result.seed_value = hash_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            in_data_reg <= text.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= stp_pkg::FNV_BASIS;
            count_reg      <= 5'd0;
            first_zero_reg <= 1'b0;
            second_x_reg   <= 1'b0;
            only_dec_reg   <= 1'b1;
            only_hex_reg   <= 1'b1;
            dec_reg        <= 64'd0;
            dec_ovf_reg    <= 1'b0;
            bare_reg       <= 64'd0;
            pfx_reg        <= 64'd0;
            pfx_open_reg   <= 1'b1;
            pfx_ovf_reg    <= 1'b0;
        end
        else if (take_last)
        begin
            hash_reg       <= stp_pkg::FNV_BASIS;
            count_reg      <= 5'd0;
            first_zero_reg <= 1'b0;
            second_x_reg   <= 1'b0;
            only_dec_reg   <= 1'b1;
            only_hex_reg   <= 1'b1;
            dec_reg        <= 64'd0;
            dec_ovf_reg    <= 1'b0;
            bare_reg       <= 64'd0;
            pfx_reg        <= 64'd0;
            pfx_open_reg   <= 1'b1;
            pfx_ovf_reg    <= 1'b0;
        end
        else if (advance)
        begin
            hash_reg       <= hash_next;
            count_reg      <= count_next;
            first_zero_reg <= first_zero_next;
            second_x_reg   <= second_x_next;
            only_dec_reg   <= only_dec_next;
            only_hex_reg   <= only_hex_next;
            dec_reg        <= dec_next;
            dec_ovf_reg    <= dec_ovf_next;
            bare_reg       <= bare_next;
            pfx_reg        <= pfx_next;
            pfx_open_reg   <= pfx_open_next;
            pfx_ovf_reg    <= pfx_ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (seed.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_last)
        begin
            out_data_reg <= result;
        end
    end

    `STP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= stp_pkg::COUNT_SATURATE)
    `STP_ASSERT_NEXT(a_state_clear, clk, rst_n, take_last, count_reg == 5'd0 && hash_reg == stp_pkg::FNV_BASIS && out_valid_reg)
    `STP_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid_reg && out_data_reg.status == stp_pkg::STATUS_EMPTY, out_data_reg.seed_value == 64'd0 && out_data_reg.path_taken == stp_pkg::PATH_PREFIX_HEX)
    `STP_ASSERT_NOW(a_range_path, clk, rst_n, out_valid_reg && out_data_reg.status == stp_pkg::STATUS_RANGE, out_data_reg.seed_value == 64'd0 && (out_data_reg.path_taken == stp_pkg::PATH_PREFIX_HEX || out_data_reg.path_taken == stp_pkg::PATH_DECIMAL))

endmodule

`default_nettype wire
